[rtl/assert_macros.svh]
// Assertion helpers for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define PCB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define PCB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/pcb_pkg.sv]
package pcb_pkg;

  localparam int PIX_W      = 8;
  localparam int HSV_FRAC   = 12;
  localparam int HUE_RANGE  = 180;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Widths of the HSV datapath, sized from the value ranges of the conversion.
  localparam int SD_W   = 20;  // saturation reciprocal, at most 255 << 12
  localparam int HD_W   = 17;  // hue reciprocal, at most 30 << 12
  localparam int HNUM_W = 12;  // signed hue numerator, -255 .. 1275
  localparam int SATP_W = 20;  // diff * saturation reciprocal
  localparam int HUEP_W = 22;  // signed hue numerator * hue reciprocal

  // Reference colours of the distance test.
  localparam logic [PIX_W-1:0] REF_BLUE_B = 8'd248;
  localparam logic [PIX_W-1:0] REF_BLUE_G = 8'd247;
  localparam logic [PIX_W-1:0] REF_BLUE_R = 8'd255;
  localparam logic [PIX_W-1:0] REF_RED_B  = 8'd241;
  localparam logic [PIX_W-1:0] REF_RED_G  = 8'd242;
  localparam logic [PIX_W-1:0] REF_RED_R  = 8'd255;

  // Hue bands: blue is above BLUE_LO up to BLUE_HI, red wraps round zero.
  localparam logic [PIX_W-1:0] HUE_BLUE_LO = 8'd100;
  localparam logic [PIX_W-1:0] HUE_BLUE_HI = 8'd124;
  localparam logic [PIX_W-1:0] HUE_RED_ABOVE = 8'd156;
  localparam logic [PIX_W-1:0] HUE_RED_UPTO  = 8'd10;

  // Register reset values.
  localparam logic [1:0]       MODE_RST     = 2'd0;
  localparam logic             ENEMY_RST    = 1'b0;
  localparam logic [PIX_W-1:0] SUM_THR_RST  = 8'd60;
  localparam logic [PIX_W-1:0] DIFF_THR_RST = 8'd30;
  localparam logic [PIX_W-1:0] SAT_LOW_RST  = 8'd25;
  localparam logic [PIX_W-1:0] SAT_HIGH_RST = 8'd160;

  typedef enum logic [1:0] {
    MODE_DIST  = 2'd0,
    MODE_HSV   = 2'd1,
    MODE_CDIFF = 2'd2
  } pcb_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE      = 3'd0,
    REG_ENEMY     = 3'd1,
    REG_SUM_THR   = 3'd2,
    REG_DIFF_THR  = 3'd3,
    REG_SAT_LOW   = 3'd4,
    REG_SAT_HIGH  = 3'd5
  } pcb_reg_t;

  localparam logic ENEMY_BLUE = 1'b0;

  // Advance strobes of the first three pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pcb_adv_t;

endpackage

[rtl/pcb_stream_if.sv]
// Pixel channel: one BGR pixel per beat.
interface pcb_pix_if import pcb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blue;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] red;

  modport source (output valid, blue, green, red, input ready);
  modport sink (input valid, blue, green, red, output ready);
  modport monitor (input valid, ready, blue, green, red);
endinterface

// Result channel: one mask bit per beat.
interface pcb_res_if import pcb_pkg::*; ();
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
  modport monitor (input valid, ready, hit);
endinterface

[rtl/pcb_hsv.sv]
// Three-stage HSV conversion: extremes and hue numerator, reciprocal
// lookup, then the two multiplications. Rounding of the products is left
// combinational at the output for the stage that follows.
module pcb_hsv import pcb_pkg::*; (
  input  logic             clk,
  input  pcb_adv_t         adv,
  input  logic [PIX_W-1:0] blue,
  input  logic [PIX_W-1:0] green,
  input  logic [PIX_W-1:0] red,
  output logic [PIX_W-1:0] hue,
  output logic [PIX_W-1:0] sat
);

  localparam int TAB_N = 1 << PIX_W;
  localparam int unsigned SdNum = 255 << HSV_FRAC;
  localparam int unsigned HdNum = HUE_RANGE << HSV_FRAC;

  // Reciprocal tables, rounded half to even; entry zero is zero.
  logic [SD_W-1:0] sd_tab [TAB_N];
  logic [HD_W-1:0] hd_tab [TAB_N];

  for (genvar i = 0; i < TAB_N; i++) begin : g_tab
    localparam int unsigned SdDen = (i == 0) ? 1 : i;
    localparam int unsigned SdQ   = SdNum / SdDen;
    localparam int unsigned SdRem = SdNum % SdDen;
    localparam int unsigned SdRnd =
      ((2 * SdRem > SdDen) || ((2 * SdRem == SdDen) && (SdQ % 2 == 1))) ? SdQ + 1 : SdQ;
    localparam int unsigned HdDen = (i == 0) ? 1 : 6 * i;
    localparam int unsigned HdQ   = HdNum / HdDen;
    localparam int unsigned HdRem = HdNum % HdDen;
    localparam int unsigned HdRnd =
      ((2 * HdRem > HdDen) || ((2 * HdRem == HdDen) && (HdQ % 2 == 1))) ? HdQ + 1 : HdQ;
    assign sd_tab[i] = (i == 0) ? '0 : SD_W'(SdRnd);
    assign hd_tab[i] = (i == 0) ? '0 : HD_W'(HdRnd);
  end

  // Stage 1: value, spread and hue numerator.
  logic [PIX_W-1:0]         vmax, vmin, spread;
  logic signed [HNUM_W-1:0] ext_b, ext_g, ext_r, ext_d, hnum;

  always_comb begin
    vmax = blue;
    vmin = blue;
    if (green > vmax) vmax = green;
    if (red > vmax) vmax = red;
    if (green < vmin) vmin = green;
    if (red < vmin) vmin = red;
    spread = vmax - vmin;
    ext_b  = HNUM_W'(blue);
    ext_g  = HNUM_W'(green);
    ext_r  = HNUM_W'(red);
    ext_d  = HNUM_W'(spread);
    priority if (vmax == red) begin
      hnum = ext_g - ext_b;
    end else if (vmax == green) begin
      hnum = ext_b - ext_r + (ext_d <<< 1);
    end else begin
      hnum = ext_r - ext_g + (ext_d <<< 2);
    end
  end

  logic [PIX_W-1:0]         v1_r, d1_r;
  logic signed [HNUM_W-1:0] hn1_r;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      v1_r  <= vmax;
      d1_r  <= spread;
      hn1_r <= hnum;
    end
  end

  // Stage 2: reciprocal lookup.
  logic [SD_W-1:0]          sd2_r;
  logic [HD_W-1:0]          hd2_r;
  logic [PIX_W-1:0]         d2_r;
  logic signed [HNUM_W-1:0] hn2_r;

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      sd2_r <= sd_tab[v1_r];
      hd2_r <= hd_tab[d1_r];
      d2_r  <= d1_r;
      hn2_r <= hn1_r;
    end
  end

  // Stage 3: products. The true values fit the register widths.
  logic signed [HUEP_W-1:0] hn_x, hd_x;
  logic [SATP_W-1:0]        satp3_r;
  logic signed [HUEP_W-1:0] huep3_r;

  assign hn_x = HUEP_W'(hn2_r);
  assign hd_x = HUEP_W'($signed({1'b0, hd2_r}));

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      satp3_r <= SATP_W'(SATP_W'(d2_r) * SATP_W'(sd2_r));
      huep3_r <= HUEP_W'(hn_x * hd_x);
    end
  end

  // Rounding and hue wrap.
  logic [SATP_W-1:0]        sat_sum;
  logic signed [HUEP_W-1:0] hue_sum;
  logic signed [PIX_W:0]    hue_raw;
  logic [PIX_W+1:0]         hue_wrap;

  assign sat_sum  = satp3_r + SATP_W'(1 << (HSV_FRAC - 1));
  assign sat      = sat_sum[HSV_FRAC +: PIX_W];
  assign hue_sum  = huep3_r + HUEP_W'(1 << (HSV_FRAC - 1));
  assign hue_raw  = hue_sum[HSV_FRAC +: PIX_W + 1];
  assign hue_wrap = {hue_raw[PIX_W], hue_raw} + (PIX_W + 2)'(HUE_RANGE);
  assign hue      = hue_raw[PIX_W] ? hue_wrap[PIX_W-1:0] : hue_raw[PIX_W-1:0];

endmodule

[rtl/pixel_color_binarizer_core.sv]
// Pipeline: an accepted pixel beat passes the HSV stages and the result register before its result beat is offered.
// Throughput: one pixel per cycle while the sink is ready; a stage holds its item while the
// one ahead is full and held, so the result register can wait while earlier stages fill.
// Reset: rst_n is synchronous and active low; it empties the pipeline and restores the
// configuration registers to their documented defaults.
module pixel_color_binarizer_core import pcb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  pcb_pix_if.sink               in_pix,
  pcb_res_if.source             out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers. Writes to an index outside the register list are
  // dropped, and each register keeps only its own low bits of the data.
  logic [1:0]       mode_r;
  logic             enemy_r;
  logic [PIX_W-1:0] sum_thr_r;
  logic [PIX_W-1:0] diff_thr_r;
  logic [PIX_W-1:0] sat_low_r;
  logic [PIX_W-1:0] sat_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_RST;
      enemy_r    <= ENEMY_RST;
      sum_thr_r  <= SUM_THR_RST;
      diff_thr_r <= DIFF_THR_RST;
      sat_low_r  <= SAT_LOW_RST;
      sat_high_r <= SAT_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MODE:     mode_r     <= cfg_data[1:0];
        REG_ENEMY:    enemy_r    <= cfg_data[0];
        REG_SUM_THR:  sum_thr_r  <= cfg_data[PIX_W-1:0];
        REG_DIFF_THR: diff_thr_r <= cfg_data[PIX_W-1:0];
        REG_SAT_LOW:  sat_low_r  <= cfg_data[PIX_W-1:0];
        REG_SAT_HIGH: sat_high_r <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control. Each stage may load when it is empty or when the
  // stage ahead of it is loading, so a bubble anywhere is squeezed out and a
  // full result register does not stop the stages behind it from filling.
  logic     v1_r, v2_r, v3_r, v4_r;
  logic     adv1, adv2, adv3, adv4;
  pcb_adv_t adv;

  assign adv4 = !v4_r || out_res.ready;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;

  assign in_pix.ready = adv1;
  assign adv          = '{s1: adv1, s2: adv2, s3: adv3};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_pix.valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  // The distance and channel-difference tests are cheap, so they are settled
  // in the first stage and their verdicts ride along beside the HSV datapath.
  logic [PIX_W-1:0] ref_b, ref_g, ref_r;
  logic [PIX_W-1:0] ad_b, ad_g, ad_r;
  logic [PIX_W+1:0] dist_sum;
  logic [PIX_W-1:0] dist_sat;
  logic [PIX_W-1:0] cdiff;
  logic             dist_hit, cdiff_hit;

  always_comb begin
    if (enemy_r == ENEMY_BLUE) begin
      ref_b = REF_BLUE_B;
      ref_g = REF_BLUE_G;
      ref_r = REF_BLUE_R;
      cdiff = (in_pix.blue > in_pix.red) ? in_pix.blue - in_pix.red : '0;
    end else begin
      ref_b = REF_RED_B;
      ref_g = REF_RED_G;
      ref_r = REF_RED_R;
      cdiff = (in_pix.red > in_pix.blue) ? in_pix.red - in_pix.blue : '0;
    end
    ad_b = (in_pix.blue > ref_b) ? in_pix.blue - ref_b : ref_b - in_pix.blue;
    ad_g = (in_pix.green > ref_g) ? in_pix.green - ref_g : ref_g - in_pix.green;
    ad_r = (in_pix.red > ref_r) ? in_pix.red - ref_r : ref_r - in_pix.red;
    // The sum is clamped at 255 before the compare, so a threshold of 255
    // accepts every pixel, however far it lies from the reference.
    dist_sum  = (PIX_W + 2)'(ad_b) + (PIX_W + 2)'(ad_g) + (PIX_W + 2)'(ad_r);
    dist_sat  = (dist_sum[PIX_W+1:PIX_W] != 2'b00) ? '1 : dist_sum[PIX_W-1:0];
    dist_hit  = dist_sat <= sum_thr_r;
    cdiff_hit = cdiff > diff_thr_r;
  end

  logic dist1_r, dist2_r, dist3_r;
  logic cdiff1_r, cdiff2_r, cdiff3_r;

  always_ff @(posedge clk) begin
    if (adv1) begin
      dist1_r  <= dist_hit;
      cdiff1_r <= cdiff_hit;
    end
    if (adv2) begin
      dist2_r  <= dist1_r;
      cdiff2_r <= cdiff1_r;
    end
    if (adv3) begin
      dist3_r  <= dist2_r;
      cdiff3_r <= cdiff2_r;
    end
  end

  // HSV conversion occupies stages one to three.
  logic [PIX_W-1:0] hue, sat;

  pcb_hsv u_hsv (
    .clk   (clk),
    .adv   (adv),
    .blue  (in_pix.blue),
    .green (in_pix.green),
    .red   (in_pix.red),
    .hue   (hue),
    .sat   (sat)
  );

  // Stage four: window tests and the mode select feed the result register.
  logic sat_ok, hue_ok, hit_nxt, hit_r;

  always_comb begin
    sat_ok = (sat > sat_low_r) && (sat <= sat_high_r);
    if (enemy_r == ENEMY_BLUE) begin
      hue_ok = (hue > HUE_BLUE_LO) && (hue <= HUE_BLUE_HI);
    end else begin
      hue_ok = (hue > HUE_RED_ABOVE) || (hue <= HUE_RED_UPTO);
    end
    // The unused mode code never passes a pixel.
    unique case (mode_r)
      MODE_DIST:  hit_nxt = dist3_r;
      MODE_HSV:   hit_nxt = sat_ok && hue_ok;
      MODE_CDIFF: hit_nxt = cdiff3_r;
      default:    hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_res.valid = v4_r;
  assign out_res.hit   = hit_r;

endmodule

[rtl/pcb_checker.sv]
`include "assert_macros.svh"

// Port-level checks of the binarizer: holding of stalled beats, pipeline timing, flow control and reset.
module pcb_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit
);

  logic in_beat;

  assign in_beat = in_valid && in_ready;

  // A result beat that is refused stays offered with the same mask bit.
  `PCB_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_hit), "result beat changed while stalled")

  // With the sink ready throughout, an accepted pixel moves through every stage and is offered at the output.
  `PCB_ASSERT(a_latency, clk, rst_n, in_beat ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid, "result missing four cycles after its pixel")

  // An empty result register never holds back the pixel channel.
  `PCB_ASSERT(a_ready_free, clk, rst_n, !out_valid |-> in_ready, "pixel channel stalled with empty output")

  // Reset empties the pipeline.
  `PCB_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result offered after reset")

endmodule

bind pixel_color_binarizer_core pcb_checker u_pcb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_pix.valid),
  .in_ready  (in_pix.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_hit   (out_res.hit)
);

[dv/pixel_color_binarizer_core_tb.sv]
`timescale 1ns / 1ps

module pixel_color_binarizer_core_tb;
  import pcb_pkg::*;

  // The settle time after the last result leaves a margin over the block's pipeline delay.
  localparam int RESET_CYCLES     = 9;
  localparam int SETTLE_CYCLES    = 8;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int RANDOM_PHASES    = 10;
  localparam int PIXELS_PER_PHASE = 95;
  localparam int DIRECTED_COUNT   = 24;
  localparam int REPORT_LINES_MAX = 200;

  // Codes that the package leaves unnamed: the spare mode value, the red colour code
  // and the two register indexes that address no register at all.
  localparam logic [1:0]           MODE_UNUSED  = 2'd3;
  localparam logic                 ENEMY_RED    = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic PINNED    = 1'b1;
  localparam logic PREDICTED = 1'b0;

  typedef struct packed {
    logic [1:0]       mode;
    logic             enemy;
    logic [PIX_W-1:0] sum_thr;
    logic [PIX_W-1:0] diff_thr;
    logic [PIX_W-1:0] sat_low;
    logic [PIX_W-1:0] sat_high;
  } setting_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pixel_t;

  // One row of the directed table: the register setting it needs, the pixel,
  // and, where the answer is obvious, the mask bit typed in by hand.
  typedef struct packed {
    setting_t cfg;
    pixel_t   px;
    logic     pinned;
    logic     hit;
  } directed_row_t;

  typedef struct packed {
    logic [31:0] seq;
    pixel_t      px;
    logic        hit;
  } hit_expect_t;

  typedef struct packed {
    logic pinned;
    logic hit;
  } pin_t;

  localparam setting_t CFG_RESET = '{MODE_RST, ENEMY_RST, SUM_THR_RST, DIFF_THR_RST,
                                     SAT_LOW_RST, SAT_HIGH_RST};
  localparam setting_t CFG_DIST_EXACT = '{MODE_DIST, ENEMY_BLUE, 8'd0, 8'd30, 8'd25, 8'd160};
  localparam setting_t CFG_DIST_LOOSE = '{MODE_DIST, ENEMY_BLUE, 8'd255, 8'd30, 8'd25, 8'd160};
  localparam setting_t CFG_DIST_RED   = '{MODE_DIST, ENEMY_RED, 8'd60, 8'd30, 8'd25, 8'd160};
  localparam setting_t CFG_HSV_BLUE   = '{MODE_HSV, ENEMY_BLUE, 8'd60, 8'd30, 8'd25, 8'd160};
  localparam setting_t CFG_HSV_RED    = '{MODE_HSV, ENEMY_RED, 8'd60, 8'd30, 8'd25, 8'd255};
  localparam setting_t CFG_HSV_SHUT   = '{MODE_HSV, ENEMY_BLUE, 8'd60, 8'd30, 8'd255, 8'd255};
  localparam setting_t CFG_HSV_OPEN   = '{MODE_HSV, ENEMY_BLUE, 8'd60, 8'd30, 8'd0, 8'd255};
  localparam setting_t CFG_CDIFF_BLUE = '{MODE_CDIFF, ENEMY_BLUE, 8'd60, 8'd30, 8'd25, 8'd160};
  localparam setting_t CFG_CDIFF_TOP  = '{MODE_CDIFF, ENEMY_BLUE, 8'd60, 8'd255, 8'd25, 8'd160};
  localparam setting_t CFG_CDIFF_RED0 = '{MODE_CDIFF, ENEMY_RED, 8'd60, 8'd0, 8'd25, 8'd160};
  localparam setting_t CFG_UNUSED     = '{MODE_UNUSED, ENEMY_BLUE, 8'd255, 8'd0, 8'd0, 8'd255};

  localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // Defaults straight after reset: the reference colour itself, a black pixel whose
    // difference sum saturates, and white, which lies close to the blue reference.
    '{CFG_RESET,      '{8'd248, 8'd247, 8'd255}, PINNED,    1'b1},
    '{CFG_RESET,      '{8'd0,   8'd0,   8'd0},   PINNED,    1'b0},
    '{CFG_RESET,      '{8'd255, 8'd255, 8'd255}, PINNED,    1'b1},
    // Sum threshold at both ends, then distance to the red reference.
    '{CFG_DIST_EXACT, '{8'd248, 8'd247, 8'd255}, PINNED,    1'b1},
    '{CFG_DIST_EXACT, '{8'd249, 8'd247, 8'd255}, PINNED,    1'b0},
    '{CFG_DIST_LOOSE, '{8'd0,   8'd0,   8'd0},   PINNED,    1'b1},
    '{CFG_DIST_RED,   '{8'd241, 8'd242, 8'd255}, PINNED,    1'b1},
    '{CFG_DIST_RED,   '{8'd248, 8'd247, 8'd255}, PREDICTED, 1'b0},
    // HSV: pure and mixed blues, black, grey, reds, a blue/red tie for the maximum,
    // and a saturation window that nothing can pass, then one that is fully open.
    '{CFG_HSV_BLUE,   '{8'd255, 8'd0,   8'd0},   PREDICTED, 1'b0},
    '{CFG_HSV_BLUE,   '{8'd200, 8'd120, 8'd40},  PREDICTED, 1'b0},
    '{CFG_HSV_BLUE,   '{8'd0,   8'd0,   8'd0},   PINNED,    1'b0},
    '{CFG_HSV_BLUE,   '{8'd128, 8'd128, 8'd128}, PINNED,    1'b0},
    '{CFG_HSV_RED,    '{8'd0,   8'd0,   8'd255}, PREDICTED, 1'b0},
    '{CFG_HSV_RED,    '{8'd40,  8'd40,  8'd200}, PREDICTED, 1'b0},
    '{CFG_HSV_RED,    '{8'd200, 8'd50,  8'd200}, PREDICTED, 1'b0},
    '{CFG_HSV_SHUT,   '{8'd255, 8'd0,   8'd0},   PINNED,    1'b0},
    '{CFG_HSV_OPEN,   '{8'd255, 8'd64,  8'd0},   PREDICTED, 1'b0},
    // Channel difference: clear hit, clear miss, threshold at the top and at zero,
    // and equal channels, which give no difference at all.
    '{CFG_CDIFF_BLUE, '{8'd255, 8'd0,   8'd0},   PINNED,    1'b1},
    '{CFG_CDIFF_BLUE, '{8'd0,   8'd0,   8'd255}, PINNED,    1'b0},
    '{CFG_CDIFF_TOP,  '{8'd255, 8'd0,   8'd0},   PINNED,    1'b0},
    '{CFG_CDIFF_RED0, '{8'd0,   8'd0,   8'd1},   PINNED,    1'b1},
    '{CFG_CDIFF_RED0, '{8'd7,   8'd0,   8'd7},   PINNED,    1'b0},
    // The spare mode code never passes, however loose the thresholds.
    '{CFG_UNUSED,     '{8'd248, 8'd247, 8'd255}, PINNED,    1'b0},
    // Back to the defaults, written this time, a spare index included.
    '{CFG_RESET,      '{8'd248, 8'd247, 8'd255}, PINNED,    1'b1}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  pcb_pix_if pix_ch ();
  pcb_res_if res_ch ();

  pixel_color_binarizer_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (pix_ch),
    .out_res  (res_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Register values as the block should hold them; the predictor reads these.
  setting_t active_cfg = CFG_RESET;

  hit_expect_t expected_hits_q [$];
  pin_t        pin_q [$];

  int unsigned pixels_sent;
  int unsigned pixels_logged;
  int unsigned results_checked;
  int unsigned hits_seen;
  int unsigned error_count;
  int unsigned settings_applied;
  int unsigned cycle_count;
  bit          sender_calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor of the mask bit.
  // ---------------------------------------------------------------------------

  function automatic int abs_diff(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Division rounded to nearest, ties going to the even quotient.
  function automatic int round_div(input int num, input int den);
    int q;
    int rem;
    q   = num / den;
    rem = num % den;
    if (2 * rem > den || (2 * rem == den && q[0]))
      q++;
    return q;
  endfunction

  function automatic logic predict_hit(input pixel_t px);
    int   b, g, r;
    int   vmax, vmin, spread;
    int   sat_recip, hue_recip, sat, hue, num;
    int   dist_sum, cdiff;
    logic sat_ok;
    logic hit;
    b   = int'(px.blue);
    g   = int'(px.green);
    r   = int'(px.red);
    hit = 1'b0;
    case (active_cfg.mode)
      MODE_DIST: begin
        if (active_cfg.enemy == ENEMY_BLUE)
          dist_sum = abs_diff(b, REF_BLUE_B) + abs_diff(g, REF_BLUE_G) + abs_diff(r, REF_BLUE_R);
        else
          dist_sum = abs_diff(b, REF_RED_B) + abs_diff(g, REF_RED_G) + abs_diff(r, REF_RED_R);
        if (dist_sum > 255)
          dist_sum = 255;
        hit = (dist_sum <= int'(active_cfg.sum_thr));
      end
      MODE_HSV: begin
        vmax = b;
        vmin = b;
        if (g > vmax) vmax = g;
        if (r > vmax) vmax = r;
        if (g < vmin) vmin = g;
        if (r < vmin) vmin = r;
        spread    = vmax - vmin;
        sat_recip = (vmax == 0) ? 0 : round_div(255 << HSV_FRAC, vmax);
        hue_recip = (spread == 0) ? 0 : round_div(HUE_RANGE << HSV_FRAC, 6 * spread);
        sat       = (spread * sat_recip + (1 << (HSV_FRAC - 1))) >>> HSV_FRAC;
        // Red wins a tie for the maximum, then green.
        if (vmax == r)
          num = g - b;
        else if (vmax == g)
          num = b - r + 2 * spread;
        else
          num = r - g + 4 * spread;
        // Arithmetic shift of a signed int floors, as the hue rounding needs.
        hue = (num * hue_recip + (1 << (HSV_FRAC - 1))) >>> HSV_FRAC;
        if (hue < 0)
          hue += HUE_RANGE;
        sat_ok = (sat > int'(active_cfg.sat_low)) && (sat <= int'(active_cfg.sat_high));
        if (active_cfg.enemy == ENEMY_BLUE)
          hit = sat_ok && hue > int'(HUE_BLUE_LO) && hue <= int'(HUE_BLUE_HI);
        else
          hit = sat_ok && (hue > int'(HUE_RED_ABOVE) || hue <= int'(HUE_RED_UPTO));
      end
      MODE_CDIFF: begin
        cdiff = (active_cfg.enemy == ENEMY_BLUE) ? b - r : r - b;
        if (cdiff < 0)
          cdiff = 0;
        hit = (cdiff > int'(active_cfg.diff_thr));
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Random stimulus.
  // ---------------------------------------------------------------------------

  function automatic logic [PIX_W-1:0] near_channel(input logic [PIX_W-1:0] centre,
                                                    input int spread);
    int v;
    v = int'(centre) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0)   v = 0;
    if (v > 255) v = 255;
    return v[PIX_W-1:0];
  endfunction

  // Mostly pixels that can reach a hit in the current mode: colours close to the
  // reference, strongly blue or red pixels, greys, ties and corner colours; the rest is noise.
  function automatic pixel_t random_pixel();
    pixel_t           px;
    int               kind;
    int               spread;
    logic [PIX_W-1:0] level;
    px.blue  = 8'($urandom_range(0, 255));
    px.green = 8'($urandom_range(0, 255));
    px.red   = 8'($urandom_range(0, 255));
    kind     = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        spread = $urandom_range(1, 60);
        if (active_cfg.enemy == ENEMY_BLUE) begin
          px.blue  = near_channel(REF_BLUE_B, spread);
          px.green = near_channel(REF_BLUE_G, spread);
          px.red   = near_channel(REF_BLUE_R, spread);
        end else begin
          px.blue  = near_channel(REF_RED_B, spread);
          px.green = near_channel(REF_RED_G, spread);
          px.red   = near_channel(REF_RED_R, spread);
        end
      end
      4, 5: begin
        // Noise: the uniform draw above stands.
      end
      6, 7: begin
        if ($urandom_range(0, 1) == 1) begin
          px.blue = 8'($urandom_range(150, 255));
          px.red  = 8'($urandom_range(0, 120));
        end else begin
          px.red  = 8'($urandom_range(150, 255));
          px.blue = 8'($urandom_range(0, 120));
        end
        px.green = 8'($urandom_range(0, 160));
      end
      8: begin
        level    = 8'($urandom_range(0, 255));
        px.blue  = level;
        px.red   = level;
        px.green = ($urandom_range(0, 1) == 1) ? level : 8'($urandom_range(0, 255));
      end
      default: begin
        px.blue  = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        px.green = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        px.red   = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
      end
    endcase
    return px;
  endfunction

  function automatic logic [PIX_W-1:0] pick_threshold(input int lo, input int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0)
      return 8'd0;
    if (r == 1)
      return 8'd255;
    return 8'($urandom_range(lo, hi));
  endfunction

  function automatic setting_t random_setting();
    setting_t s;
    s.mode     = ($urandom_range(0, 11) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
    s.enemy    = 1'($urandom_range(0, 1));
    s.sum_thr  = pick_threshold(0, 150);
    s.diff_thr = pick_threshold(0, 200);
    s.sat_low  = pick_threshold(0, 120);
    s.sat_high = pick_threshold(int'(s.sat_low), 255);
    return s;
  endfunction

  // Gap before a pixel beat: mostly none, often a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (sender_calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 65)
      return 0;
    if (r < 93)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving tasks. Each is entered and left just after a rising edge.
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    error_count++;
    // Past this many lines the failures are only counted.
    if (error_count <= REPORT_LINES_MAX)
      $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Holds the pixel channel idle until every result is back, then lets the
  // pipeline settle so that a register write cannot meet a pixel in flight.
  task automatic drain_pipeline();
    pix_ch.valid <= 1'b0;
    do
      @(posedge clk);
    while (pixels_logged != pixels_sent || expected_hits_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all six registers and one spare index. Mode and colour are sent with
  // random upper bits, which the block must drop.
  task automatic apply_setting(input setting_t s);
    logic [CFG_IDX_W-1:0]  idx [7];
    logic [CFG_DATA_W-1:0] val [7];
    int                    k;
    idx[0] = REG_MODE;     val[0] = {6'($urandom), s.mode};
    idx[1] = REG_ENEMY;    val[1] = {7'($urandom), s.enemy};
    idx[2] = REG_SUM_THR;  val[2] = s.sum_thr;
    idx[3] = REG_DIFF_THR; val[3] = s.diff_thr;
    idx[4] = REG_SAT_LOW;  val[4] = s.sat_low;
    idx[5] = REG_SAT_HIGH; val[5] = s.sat_high;
    idx[6] = ($urandom_range(0, 1) == 1) ? REG_SPARE_HI : REG_SPARE_LO;
    val[6] = 8'($urandom);
    active_cfg = s;
    for (k = 0; k < 7; k++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idx[k];
      cfg_data <= val[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  task automatic send_pixel(input pixel_t px, input logic pinned, input logic hit);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.blue  <= px.blue;
    pix_ch.green <= px.green;
    pix_ch.red   <= px.red;
    pin_q = {pin_q, pin_t'{pinned, hit}};
    do
      @(posedge clk);
    while (!pix_ch.ready);
    pixels_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random stalls, short ones mostly and long ones rarely. While bits 9:8 of
  // the cycle count are zero it starts no new stall, and takes each beat once the last ends.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    int r;
    stall_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      r = $urandom_range(0, 99);
      if (!rst_n) begin
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (cycle_count[9:8] == 2'b00 || r < 70) begin
        res_ch.ready <= 1'b1;
      end else begin
        stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        res_ch.ready <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard. A result beat is checked before the pixel beat of the same edge
  // is logged; the block cannot answer a pixel in the cycle that accepts it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    hit_expect_t oldest;
    hit_expect_t fresh;
    pin_t        pin;
    if (rst_n) begin
      if (res_ch.valid && res_ch.ready) begin
        results_checked++;
        if (res_ch.hit === 1'b1)
          hits_seen++;
        if (expected_hits_q.size() == 0) begin
          report_mismatch($sformatf("result beat (hit %b) with no pixel outstanding",
                                    res_ch.hit));
        end else begin
          oldest = expected_hits_q.pop_front();
          if (res_ch.hit !== oldest.hit)
            report_mismatch($sformatf("pixel %0d (b %0d g %0d r %0d): hit %b, expected %b",
                                      oldest.seq, oldest.px.blue, oldest.px.green,
                                      oldest.px.red, res_ch.hit, oldest.hit));
        end
      end
      if (pix_ch.valid && pix_ch.ready) begin
        pin       = (pin_q.size() != 0) ? pin_q.pop_front() : '0;
        fresh.seq = pixels_logged;
        fresh.px  = '{pix_ch.blue, pix_ch.green, pix_ch.red};
        fresh.hit = pin.pinned ? pin.hit : predict_hit(fresh.px);
        expected_hits_q = {expected_hits_q, fresh};
        pixels_logged++;
      end
    end
  end

  // Watchdog: the slowest correct run stays well below this many cycles.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               expected_hits_q.size());
      $display("pixel_color_binarizer_core_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: reset, the directed table, then random phases, each under a fresh
  // register setting written while the block is empty.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int i;
    int phase;
    int n;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= REG_MODE;
    cfg_data     <= '0;
    pix_ch.valid <= 1'b0;
    pix_ch.blue  <= '0;
    pix_ch.green <= '0;
    pix_ch.red   <= '0;
    sender_calm  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first rows run on the reset values; a row that needs another setting
    // waits for the pipeline to empty before the registers are written.
    for (i = 0; i < DIRECTED_COUNT; i++) begin
      if (DIRECTED_ROWS[i].cfg != active_cfg) begin
        drain_pipeline();
        apply_setting(DIRECTED_ROWS[i].cfg);
      end
      send_pixel(DIRECTED_ROWS[i].px, DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].hit);
    end

    // Every third phase the sender runs without gaps, so that the sink's stalls
    // alone decide how full the pipeline gets.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_pipeline();
      apply_setting(random_setting());
      sender_calm = (phase % 3 == 1);
      for (n = 0; n < PIXELS_PER_PHASE; n++)
        send_pixel(random_pixel(), PREDICTED, 1'b0);
    end

    drain_pipeline();
    if (expected_hits_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_hits_q.size()));

    $display("Covered %0d pixels under %0d register settings: all mode codes, both colours,",
             pixels_logged, settings_applied);
    $display("threshold extremes and spare indexes; %0d of %0d results were hits, %0d errors.",
             hits_seen, results_checked, error_count);
    if (error_count == 0)
      $display("pixel_color_binarizer_core_tb: PASS");
    else
      $display("pixel_color_binarizer_core_tb: FAIL");
    $finish;
  end

endmodule

[pixel_color_binarizer_core.f]
+incdir+rtl
rtl/pcb_pkg.sv
rtl/pcb_stream_if.sv
rtl/pcb_hsv.sv
rtl/pixel_color_binarizer_core.sv
rtl/pcb_checker.sv
dv/pixel_color_binarizer_core_tb.sv
